// File: hw/rtl/tccw_pkg.sv
`default_nettype none

package tccw_pkg;

   // Field widths of the request, response and CSR ports.
   localparam int FUNC_W         = 2;
   localparam int CHAR_W         = 8;
   localparam int CELL_ADDRESS_W = 11;
   localparam int CURSOR_ROW_W   = 5;
   localparam int CURSOR_COL_W   = 7;
   localparam int CURSOR_INDEX_W = 11;
   localparam int CELL_W         = 16;
   localparam int ATTR_W         = 8;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   // Character codes with a cursor meaning, and the space used to fill cleared cells.
   localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CODE_LF        = 8'h0A;
   localparam logic [CHAR_W-1:0] CODE_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0] SPACE_CHAR     = 8'h20;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_FILL,
      ST_DONE
   } seq_state_type;

endpackage

`default_nettype wire

// File: hw/rtl/text_console_char_writer.sv
// A put-character request that does not scroll shows its response in the cycle after
// acceptance, and the block takes one such request per cycle while rsp_stall is low.
// A read passes through the READ and DONE states. A clear or a scroll runs the single
// sweep counter, which walks the screen RAM one cell per cycle.
// Reset (synchronous, active high) homes the cursor and sets the attribute to 0x0F.
// The screen RAM is not reset; its cells are undefined until written.
`default_nettype none

module text_console_char_writer #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [tccw_pkg::FUNC_W-1:0]          req_func,
   input  wire logic [tccw_pkg::CHAR_W-1:0]          req_char_code,
   input  wire logic [tccw_pkg::CELL_ADDRESS_W-1:0]  req_cell_address,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [tccw_pkg::CURSOR_ROW_W-1:0]    rsp_cursor_row,
   output logic      [tccw_pkg::CURSOR_COL_W-1:0]    rsp_cursor_col,
   output logic      [tccw_pkg::CURSOR_INDEX_W-1:0]  rsp_cursor_index,
   output logic      [tccw_pkg::CELL_W-1:0]          rsp_read_data,
   output logic                                      rsp_scrolled,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [tccw_pkg::ATTR_W-1:0]          csr_text_attribute
);

   import tccw_pkg::*;

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int COPY_COUNT = COLUMNS * (ROWS - 1);
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int PH_W       = $clog2(TAB_WIDTH);
   localparam int COLX_W     = $clog2(COLUMNS + TAB_WIDTH);

   seq_state_type state_ff, state_in;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [PH_W-1:0]   phase_ff, phase_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic              sweep_we_ff, sweep_we_in;
   logic [AW-1:0]     sweep_addr_ff, sweep_addr_in;
   logic              sweep_from_ram_ff, sweep_from_ram_in;
   logic              in_range_ff, in_range_in;
   logic [CELL_W-1:0] res_read_data_ff, res_read_data_in;
   logic              res_scrolled_ff, res_scrolled_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_ROW_W-1:0]   rsp_cursor_row_ff, rsp_cursor_row_in;
   logic [CURSOR_COL_W-1:0]   rsp_cursor_col_ff, rsp_cursor_col_in;
   logic [CURSOR_INDEX_W-1:0] rsp_cursor_index_ff, rsp_cursor_index_in;
   logic [CELL_W-1:0]         rsp_read_data_ff, rsp_read_data_in;
   logic                      rsp_scrolled_ff, rsp_scrolled_in;

   logic              accept;
   logic              out_free;
   logic              load_out;
   logic              char_we;
   logic [COLX_W-1:0] tab_col;
   logic [COL_W-1:0]  step_col;
   logic [ROW_W-1:0]  step_row;
   logic [PH_W-1:0]   step_phase;
   logic              step_line_adv;
   logic              step_write;
   logic              step_scroll;

   logic              ram_we;
   logic [AW-1:0]     ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic [AW-1:0]     ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Cursor step for a put-character request. The tab phase tracks the column modulo the
   // tab width so that a tab only needs an add and a subtract.
   assign tab_col = COLX_W'(col_ff) + COLX_W'(TAB_WIDTH) - COLX_W'(phase_ff);

   always_comb begin
      step_col      = col_ff;
      step_phase    = phase_ff;
      step_line_adv = 1'b0;
      step_write    = 1'b0;
      case (req_char_code)
         CODE_BACKSPACE: begin
            if (col_ff != '0) begin
               step_col   = col_ff - 1'b1;
               step_phase = (phase_ff == '0) ? PH_W'(TAB_WIDTH - 1) : phase_ff - 1'b1;
            end
         end
         CODE_TAB: begin
            if (tab_col >= COLX_W'(COLUMNS)) begin
               step_line_adv = 1'b1;
            end else begin
               step_col   = COL_W'(tab_col);
               step_phase = '0;
            end
         end
         CODE_CR, CODE_LF: begin
            step_line_adv = 1'b1;
         end
         default: begin
            step_write = 1'b1;
            if (col_ff == COL_W'(COLUMNS - 1)) begin
               step_line_adv = 1'b1;
            end else begin
               step_col   = col_ff + 1'b1;
               step_phase = (phase_ff == PH_W'(TAB_WIDTH - 1)) ? '0 : phase_ff + 1'b1;
            end
         end
      endcase
      if (step_line_adv) begin
         step_col   = '0;
         step_phase = '0;
      end
      step_scroll = step_line_adv && (row_ff == ROW_W'(ROWS - 1));
      step_row    = (step_line_adv && !step_scroll) ? row_ff + 1'b1 : row_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_PUT:   state_in = step_scroll ? ST_COPY : ST_IDLE;
                  FUNC_CLEAR: state_in = ST_FILL;
                  FUNC_READ:  state_in = ST_READ;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_COPY: begin
            if (cnt_ff == AW'(COPY_COUNT - 1)) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (cnt_ff == AW'(CELL_COUNT - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs of the sequencer.
   always_comb begin
      col_in            = col_ff;
      row_in            = row_ff;
      phase_in          = phase_ff;
      attr_in           = attr_ff;
      cnt_in            = cnt_ff;
      sweep_we_in       = 1'b0;
      sweep_addr_in     = cnt_ff;
      sweep_from_ram_in = 1'b0;
      in_range_in       = in_range_ff;
      res_read_data_in  = res_read_data_ff;
      res_scrolled_in   = res_scrolled_ff;
      char_we           = 1'b0;
      load_out          = 1'b0;
      ram_rd_addr       = AW'(req_cell_address);
      rsp_read_data_in  = res_read_data_ff;
      rsp_scrolled_in   = res_scrolled_ff;

      if (csr_valid && csr_ready) begin
         attr_in = csr_text_attribute;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_read_data_in = '0;
               res_scrolled_in  = 1'b0;
               rsp_read_data_in = '0;
               rsp_scrolled_in  = 1'b0;
               in_range_in      = 32'(req_cell_address) < 32'(CELL_COUNT);
               cnt_in           = '0;
               case (req_func)
                  FUNC_PUT: begin
                     char_we         = step_write;
                     col_in          = step_col;
                     row_in          = step_row;
                     phase_in        = step_phase;
                     res_scrolled_in = step_scroll;
                     load_out        = !step_scroll;
                  end
                  FUNC_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     phase_in = '0;
                  end
                  FUNC_READ: begin
                  end
                  default: begin
                     load_out = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            res_read_data_in = in_range_ff ? ram_rd_data : '0;
         end
         ST_COPY: begin
            // Read one row below; the write back lands in the next cycle with the RAM data.
            ram_rd_addr       = AW'(cnt_ff + AW'(COLUMNS));
            sweep_we_in       = 1'b1;
            sweep_from_ram_in = 1'b1;
            cnt_in            = cnt_ff + 1'b1;
         end
         ST_FILL: begin
            sweep_we_in = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
         end
         ST_DONE: begin
            load_out = out_free;
         end
         default: begin
         end
      endcase

      idx_in = AW'(int'(row_in) * COLUMNS + int'(col_in));

      rsp_cursor_row_in   = CURSOR_ROW_W'(row_in);
      rsp_cursor_col_in   = CURSOR_COL_W'(col_in);
      rsp_cursor_index_in = CURSOR_INDEX_W'(idx_in);

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign ram_we      = sweep_we_ff || char_we;
   assign ram_wr_addr = sweep_we_ff ? sweep_addr_ff : idx_ff;
   assign ram_wr_data = (sweep_we_ff && sweep_from_ram_ff) ? ram_rd_data :
                        sweep_we_ff ? {attr_ff, SPACE_CHAR} :
                        {attr_ff, req_char_code};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         phase_ff     <= '0;
         idx_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         sweep_we_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         attr_ff      <= attr_in;
         sweep_we_ff  <= sweep_we_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff            <= cnt_in;
      sweep_addr_ff     <= sweep_addr_in;
      sweep_from_ram_ff <= sweep_from_ram_in;
      in_range_ff       <= in_range_in;
      res_read_data_ff  <= res_read_data_in;
      res_scrolled_ff   <= res_scrolled_in;
      if (load_out) begin
         rsp_cursor_row_ff   <= rsp_cursor_row_in;
         rsp_cursor_col_ff   <= rsp_cursor_col_in;
         rsp_cursor_index_ff <= rsp_cursor_index_in;
         rsp_read_data_ff    <= rsp_read_data_in;
         rsp_scrolled_ff     <= rsp_scrolled_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_row   = rsp_cursor_row_ff;
   assign rsp_cursor_col   = rsp_cursor_col_ff;
   assign rsp_cursor_index = rsp_cursor_index_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_scrolled     = rsp_scrolled_ff;

   tccw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < 32'(ROWS)) && (32'(col_ff) < 32'(COLUMNS)))
      else $error("cursor left the screen");

   a_index_match: assert property (@(posedge clock) disable iff (reset)
      idx_ff == AW'(int'(row_ff) * COLUMNS + int'(col_ff)))
      else $error("cursor index out of step with row and column");

   a_write_port: assert property (@(posedge clock) disable iff (reset)
      !(sweep_we_ff && char_we))
      else $error("sweep write collides with a character write");

   a_copy_next: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY |=> state_ff == ST_COPY || state_ff == ST_FILL)
      else $error("scroll copy left for a wrong state");

   a_clear_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && accept && req_func == FUNC_CLEAR)
      |=> row_ff == '0 && col_ff == '0 && state_ff == ST_FILL)
      else $error("clear did not home the cursor");

endmodule

`default_nettype wire

// File: hw/rtl/tccw_ram.sv
`default_nettype none

module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire
